FILE: src/icpr_pkg.sv
package icpr_pkg;

	// Default depth of the receive buffer in bytes.
	localparam int unsigned DEF_MAX_PACKET_BYTES = 2048;

	// Protocol codes that the classifier looks for.
	localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] ICMP_CODE_IN_TRANSIT    = 8'd0;
	localparam logic [7:0] ICMP_TYPE_UNREACHABLE   = 8'd3;
	localparam logic [7:0] ICMP_CODE_PORT          = 8'd3;
	localparam logic [7:0] IP_PROTOCOL_UDP         = 8'd17;

	// Byte offsets relative to the start of the ICMP header.
	localparam logic [7:0] OFS_CODE      = 8'd1;
	localparam logic [7:0] OFS_INNER_HDR = 8'd8;
	localparam logic [7:0] OFS_PROTOCOL  = 8'd17;

	// Minimum packet lengths beyond the outer header.
	localparam logic [7:0] LEN_ICMP_HDR   = 8'd8;
	localparam logic [7:0] LEN_QUOTED_HDR = 8'd28;
	localparam logic [7:0] LEN_PORTS      = 8'd12;

	// Register file.
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [15:0] BASE_DEST_PORT_RESET = 16'd33434;

	typedef enum logic {
		REG_SOURCE_PORT    = 1'b0,
		REG_BASE_DEST_PORT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		VERDICT_NO_MATCH      = 2'd0,
		VERDICT_TIME_EXCEEDED = 2'd1,
		VERDICT_PORT_UNREACH  = 2'd2,
		VERDICT_OTHER_UNREACH = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [15:0] source_port;
		logic [15:0] base_dest_port;
	} cfg_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] msg_type;
		logic [7:0] msg_code;
	} result_t;

endpackage

FILE: src/icmp_probe_reply_classifier.sv
// Classifies a received IPv4 packet as a reply to an outstanding UDP probe.
// The packet arrives on the input channel one byte per request in wire order;
// last_byte marks its final byte and probe_seq is sampled with the first.
// On the final byte one result request leaves on the output channel with the
// verdict and the ICMP type and code bytes; other bytes give no result.
// Each byte passes through an input register and one stage of field capture
// and match logic; a byte can be taken in every cycle while no final byte is
// held there; the result enters the output register as that byte moves on.
// When the receiver stalls, the result waits in the output register and the
// bytes of the next packet keep flowing; only the next final byte is held
// until the output register has been emptied.
// The APB port sets the probe source port (address 0) and the base
// destination port (address 4); write them only while no packet is in flight.
// Reset empties both registers, clears the packet state and loads the
// register defaults; no clearing pass follows it. Bytes beyond
// MAX_PACKET_BYTES are dropped.
module icmp_probe_reply_classifier #(
	parameter int unsigned MAX_PACKET_BYTES = icpr_pkg::DEF_MAX_PACKET_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      packet_byte,
	input  logic                            last_byte,
	input  logic [15:0]                     probe_seq,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      verdict,
	output logic [7:0]                      msg_type,
	output logic [7:0]                      msg_code,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [icpr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	icpr_pkg::cfg_t    cfg;
	icpr_pkg::result_t result;
	logic              res_valid;
	logic              res_free;

	icpr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	icpr_parser #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (packet_byte),
		.in_last   (last_byte),
		.in_seq    (probe_seq),
		.cfg       (cfg),
		.res_free  (res_free),
		.res_valid (res_valid),
		.result    (result)
	);

	icpr_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.result    (result),
		.res_free  (res_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.msg_type  (msg_type),
		.msg_code  (msg_code)
	);

endmodule

FILE: src/icpr_cfg_regs.sv
module icpr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [icpr_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output icpr_pkg::cfg_t                     cfg
);

	icpr_pkg::reg_index_t index;

	assign index  = icpr_pkg::reg_index_t'(paddr[2]);
	assign pready = 1'b1;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.source_port    <= 16'd0;
			cfg.base_dest_port <= icpr_pkg::BASE_DEST_PORT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (index)
				icpr_pkg::REG_SOURCE_PORT:    cfg.source_port    <= pwdata[15:0];
				icpr_pkg::REG_BASE_DEST_PORT: cfg.base_dest_port <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the selected register.
	always_comb begin
		unique case (index)
			icpr_pkg::REG_SOURCE_PORT:    prdata = {16'd0, cfg.source_port};
			icpr_pkg::REG_BASE_DEST_PORT: prdata = {16'd0, cfg.base_dest_port};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/icpr_parser.sv
module icpr_parser #(
	parameter int unsigned MAX_PACKET_BYTES = icpr_pkg::DEF_MAX_PACKET_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic [15:0]       in_seq,
	input  icpr_pkg::cfg_t    cfg,
	input  logic              res_free,
	output logic              res_valid,
	output icpr_pkg::result_t result
);

	localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned XW = CW + 8;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [15:0] seq_s1;

	// Per-packet state.
	logic [CW-1:0] count_q;
	logic [5:0]    outer_len_q;
	logic [7:0]    type_q;
	logic [7:0]    code_q;
	logic [5:0]    inner_len_q;
	logic [7:0]    proto_q;
	logic [15:0]   src_port_q;
	logic [15:0]   dst_port_q;
	logic [15:0]   exp_port_q;

	logic          advance;
	logic          load;
	logic          first;
	logic          absorb;
	logic [5:0]    len_from_byte;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] h_x;
	logic [XW-1:0] q_x;
	logic [XW-1:0] n_x;
	logic [CW-1:0] count_n;
	logic [5:0]    outer_len_n;
	logic [7:0]    type_n;
	logic [7:0]    code_n;
	logic [5:0]    inner_len_n;
	logic [7:0]    proto_n;
	logic [15:0]   src_port_n;
	logic [15:0]   dst_port_n;
	logic [15:0]   exp_port_n;
	logic          exceeded;
	logic          unreach;
	logic          too_short;
	logic          quote_short;
	logic          ports_ok;

	// A byte moves on unless it ends a packet and the result slot is full.
	assign advance  = valid_s1 && (!last_s1 || res_free);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
			seq_s1  <= in_seq;
		end
	end

	// Field capture for the byte at the current position.
	always_comb begin
		first         = (count_q == '0);
		absorb        = (count_q < CW'(MAX_PACKET_BYTES));
		len_from_byte = {byte_s1[3:0], 2'b00};
		pos_x         = XW'(count_q);

		outer_len_n = first ? len_from_byte : outer_len_q;
		h_x         = XW'(outer_len_n);

		type_n = (absorb && pos_x == h_x) ? byte_s1 : type_q;
		code_n = (absorb && pos_x == h_x + XW'(icpr_pkg::OFS_CODE)) ? byte_s1 : code_q;
		inner_len_n = (absorb && pos_x == h_x + XW'(icpr_pkg::OFS_INNER_HDR)) ?
			len_from_byte : inner_len_q;
		proto_n = (absorb && pos_x == h_x + XW'(icpr_pkg::OFS_PROTOCOL)) ?
			byte_s1 : proto_q;

		q_x = h_x + XW'(icpr_pkg::OFS_INNER_HDR) + XW'(inner_len_n);
		src_port_n[15:8] = (absorb && pos_x == q_x) ? byte_s1 : src_port_q[15:8];
		src_port_n[7:0]  = (absorb && pos_x == q_x + XW'(1)) ? byte_s1 : src_port_q[7:0];
		dst_port_n[15:8] = (absorb && pos_x == q_x + XW'(2)) ? byte_s1 : dst_port_q[15:8];
		dst_port_n[7:0]  = (absorb && pos_x == q_x + XW'(3)) ? byte_s1 : dst_port_q[7:0];

		exp_port_n = first ? 16'(cfg.base_dest_port + seq_s1) : exp_port_q;
		count_n    = absorb ? (count_q + CW'(1)) : count_q;
	end

	// Length and match rules on the state after this byte.
	always_comb begin
		n_x         = XW'(count_n);
		too_short   = (n_x < h_x + XW'(icpr_pkg::LEN_ICMP_HDR));
		quote_short = (n_x < h_x + XW'(icpr_pkg::LEN_QUOTED_HDR)) ||
			(n_x < h_x + XW'(icpr_pkg::LEN_PORTS) + XW'(inner_len_n));
		exceeded = (type_n == icpr_pkg::ICMP_TYPE_TIME_EXCEEDED) &&
			(code_n == icpr_pkg::ICMP_CODE_IN_TRANSIT);
		unreach  = (type_n == icpr_pkg::ICMP_TYPE_UNREACHABLE);
		ports_ok = (proto_n == icpr_pkg::IP_PROTOCOL_UDP) &&
			(src_port_n == cfg.source_port) && (dst_port_n == exp_port_n);

		priority if (too_short || (!exceeded && !unreach) || quote_short || !ports_ok) begin
			result.verdict = icpr_pkg::VERDICT_NO_MATCH;
		end else if (exceeded) begin
			result.verdict = icpr_pkg::VERDICT_TIME_EXCEEDED;
		end else if (code_n == icpr_pkg::ICMP_CODE_PORT) begin
			result.verdict = icpr_pkg::VERDICT_PORT_UNREACH;
		end else begin
			result.verdict = icpr_pkg::VERDICT_OTHER_UNREACH;
		end
		result.msg_type = type_n;
		result.msg_code = code_n;
	end

	assign res_valid = advance && last_s1;

	// State update; a final byte clears everything for the next packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			outer_len_q <= 6'd0;
			type_q      <= 8'd0;
			code_q      <= 8'd0;
			inner_len_q <= 6'd0;
			proto_q     <= 8'd0;
			src_port_q  <= 16'd0;
			dst_port_q  <= 16'd0;
			exp_port_q  <= 16'd0;
		end else if (advance) begin
			if (last_s1) begin
				count_q     <= '0;
				outer_len_q <= 6'd0;
				type_q      <= 8'd0;
				code_q      <= 8'd0;
				inner_len_q <= 6'd0;
				proto_q     <= 8'd0;
				src_port_q  <= 16'd0;
				dst_port_q  <= 16'd0;
				exp_port_q  <= 16'd0;
			end else begin
				count_q     <= count_n;
				outer_len_q <= outer_len_n;
				type_q      <= type_n;
				code_q      <= code_n;
				inner_len_q <= inner_len_n;
				proto_q     <= proto_n;
				src_port_q  <= src_port_n;
				dst_port_q  <= dst_port_n;
				exp_port_q  <= exp_port_n;
			end
		end
	end

	// An empty input register never holds off the sender.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	// Bytes inside a packet are never held back by the output side.
	a_mid_packet_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> !in_stall)
		else $error("mid-packet byte stalled");

	// The byte count restarts after every final byte.
	a_count_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (count_q == '0))
		else $error("byte count not cleared after final byte");

	// The byte count saturates at the buffer size.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PACKET_BYTES))
		else $error("byte count beyond buffer size");

endmodule

FILE: src/icpr_out_stage.sv
module icpr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  icpr_pkg::result_t result,
	output logic              res_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        verdict,
	output logic [7:0]        msg_type,
	output logic [7:0]        msg_code
);

	logic              valid_q;
	icpr_pkg::result_t result_q;

	// The slot takes a new result once the old one is gone or leaving.
	assign res_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			result_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign verdict   = result_q.verdict;
	assign msg_type  = result_q.msg_type;
	assign msg_code  = result_q.msg_code;

endmodule
